// ===== design/csvs_pkg.sv =====
// Package for the CSV field splitter: payload structs, byte codes,
// result kinds and the quote-mode state encoding. No dependencies.
package csvs_pkg;

    // Width of the field counter and of the field index in a result transaction
    localparam int FIELD_INDEX_BITS = 8;

    // Stream byte codes
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Result kinds
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_FIELD  = 2'd1;
    localparam logic [1:0] KIND_RECORD = 2'd2;

    // Quote tracking state, one-hot
    typedef enum logic [2:0] {
        QM_PLAIN   = 3'b001,
        QM_QUOTED  = 3'b010,
        QM_PENDING = 3'b100
    } t_quote_mode;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [7:0]                  out_byte;
        logic [1:0]                  kind;
        logic [FIELD_INDEX_BITS-1:0] field_index;
        logic                        bad_record;
    } t_out_item;

    // Scanner state other than the field counter
    typedef struct packed {
        t_quote_mode quote_mode;
        logic        line_started;
    } t_scan_state;

endpackage

// ===== design/csvs_step.sv =====
// One scanning step of the CSV field splitter: current state and one input
// transaction in, next state and at most one result out. Uses csvs_pkg.
module csvs_step (
    input  csvs_pkg::t_scan_state                  i_state,
    input  logic [csvs_pkg::FIELD_INDEX_BITS-1:0]  i_field_cnt,
    input  csvs_pkg::t_in_item                     i_item,
    output csvs_pkg::t_scan_state                  o_state,
    output logic [csvs_pkg::FIELD_INDEX_BITS-1:0]  o_field_cnt,
    output logic                                   o_res_valid,
    output csvs_pkg::t_out_item                    o_res
);
    import csvs_pkg::*;

    localparam logic [FIELD_INDEX_BITS-1:0] FIELD_MAX = '1;

    logic [7:0]  c;
    t_quote_mode mode;
    logic        do_plain;

    assign c = i_item.in_byte;

    always_comb begin
        // Treat any unexpected mode code as unquoted
        case (i_state.quote_mode)
            QM_QUOTED:  mode = QM_QUOTED;
            QM_PENDING: mode = QM_PENDING;
            default:    mode = QM_PLAIN;
        endcase

        o_state                 = i_state;
        o_state.quote_mode      = mode;
        o_field_cnt             = i_field_cnt;
        o_res_valid             = 1'b0;
        o_res.out_byte          = 8'd0;
        o_res.kind              = KIND_BYTE;
        o_res.field_index       = i_field_cnt;
        o_res.bad_record        = 1'b0;
        do_plain                = 1'b0;

        if (i_item.end_of_input || c == CH_LF) begin
            // Close the record; a pending quote counts as the closing quote
            if (mode == QM_PENDING) begin
                o_state.quote_mode = QM_PLAIN;
            end
            if (i_state.line_started) begin
                o_res_valid          = 1'b1;
                o_res.kind           = KIND_RECORD;
                o_res.bad_record     = (mode == QM_QUOTED);
                o_state.quote_mode   = QM_PLAIN;
                o_state.line_started = 1'b0;
                o_field_cnt          = '0;
            end
        end else begin
            o_state.line_started = 1'b1;
            case (mode)
                QM_QUOTED: begin
                    if (c == CH_QUOTE) begin
                        o_state.quote_mode = QM_PENDING;
                    end else begin
                        o_res_valid    = 1'b1;
                        o_res.out_byte = c;
                    end
                end
                QM_PENDING: begin
                    // Doubled quote gives one literal quote
                    if (c == CH_QUOTE) begin
                        o_state.quote_mode = QM_QUOTED;
                        o_res_valid        = 1'b1;
                        o_res.out_byte     = CH_QUOTE;
                    end else begin
                        o_state.quote_mode = QM_PLAIN;
                        do_plain           = 1'b1;
                    end
                end
                default: begin
                    do_plain = 1'b1;
                end
            endcase

            // Unquoted byte handling
            if (do_plain) begin
                if (c == CH_QUOTE) begin
                    o_state.quote_mode = QM_QUOTED;
                end else if (c == CH_COMMA) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_FIELD;
                    if (i_field_cnt != FIELD_MAX) begin
                        o_field_cnt = i_field_cnt + 1'b1;
                    end
                end else if (c != CH_CR) begin
                    o_res_valid    = 1'b1;
                    o_res.out_byte = c;
                end
            end
        end
    end

endmodule

// ===== design/csv_record_field_splitter_core.sv =====
// CSV record/field splitter: one stream byte per transaction, at most one result.
// Each byte passes the input register, then its result sits in the result register.
// Throughput: one byte per cycle while the result side takes a result every cycle;
// the limit is the single scan-state update done per cycle.
// Reset (synchronous, active low) empties both registers and returns the scanner to
// unquoted mode, no record started, field counter zero.
module csv_record_field_splitter_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  csvs_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output csvs_pkg::t_out_item o_out_data
);
    import csvs_pkg::*;

    logic                        r_in_valid;
    t_in_item                    r_in_data;
    t_scan_state                 r_state;
    t_scan_state                 n_state;
    logic [FIELD_INDEX_BITS-1:0] r_field_cnt;
    logic [FIELD_INDEX_BITS-1:0] n_field_cnt;
    logic                        r_out_valid;
    t_out_item                   r_out_data;
    logic                        step_valid;
    t_out_item                   step_res;
    logic                        advance;

    // Move the held item through the scanner when the result slot is free
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    csvs_step u_step (
        .i_state     (r_state),
        .i_field_cnt (r_field_cnt),
        .i_item      (r_in_data),
        .o_state     (n_state),
        .o_field_cnt (n_field_cnt),
        .o_res_valid (step_valid),
        .o_res       (step_res)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_in_data <= i_in_data;
        end
    end

    // Scanner state, updated once per processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.quote_mode   <= QM_PLAIN;
            r_state.line_started <= 1'b0;
            r_field_cnt          <= '0;
        end else if (advance) begin
            r_state     <= n_state;
            r_field_cnt <= n_field_cnt;
        end
    end

    // Result register; hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && step_valid) begin
            r_out_data <= step_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== design/csvs_checker.sv =====
// Port-level checks for csv_record_field_splitter_core, attached by bind.
// Uses csvs_pkg for payload types and result kinds.
module csvs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input csvs_pkg::t_out_item o_out_data
);
    import csvs_pkg::*;

    // Result transaction holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // Only the three defined kinds appear
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.kind == KIND_BYTE || o_out_data.kind == KIND_FIELD
                         || o_out_data.kind == KIND_RECORD))
        else $error("illegal result kind");

    // Bad flag only on record ends
    a_bad_on_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.bad_record |-> o_out_data.kind == KIND_RECORD)
        else $error("bad flag outside record end");

    // Field and record ends carry no byte
    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind != KIND_BYTE |-> o_out_data.out_byte == 8'd0)
        else $error("marker result carries a byte");

    // No result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind csv_record_field_splitter_core csvs_checker u_csvs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== verif/tb_csv_record_field_splitter_core.sv =====
// Self-checking testbench for csv_record_field_splitter_core: directed table, then random
// CSV records and noise under several idle/stall mixes, checked against a local predictor.
// Depends on csvs_pkg and the core RTL only.
module tb_csv_record_field_splitter_core;
    import csvs_pkg::*;

    localparam int FLD_BITS    = FIELD_INDEX_BITS;
    localparam int FLD_MAX     = (1 << FLD_BITS) - 1;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 180;
    localparam int DIR_N       = 25;

    // Idle and stall percentages per random phase
    localparam int SEND_IDLE  [0:3] = '{0, 62, 0, 26};
    localparam int RECV_STALL [0:3] = '{0, 0, 62, 26};

    // One directed row: the input and, where fixed is set, the typed-in result
    typedef struct packed {
        t_in_item  item;
        logic      fixed;
        logic      has_res;
        t_out_item res;
    } t_dir_row;

    localparam t_out_item NO_RES = '0;

    localparam t_dir_row DIR_ROWS [0:DIR_N-1] = '{
        '{'{8'h61, 1'b0},    1'b1, 1'b1, '{8'h61, KIND_BYTE, 8'd0, 1'b0}},
        '{'{CH_COMMA, 1'b0}, 1'b1, 1'b1, '{8'h00, KIND_FIELD, 8'd0, 1'b0}},
        '{'{8'h00, 1'b0},    1'b1, 1'b1, '{8'h00, KIND_BYTE, 8'd1, 1'b0}},
        '{'{8'hFF, 1'b0},    1'b1, 1'b1, '{8'hFF, KIND_BYTE, 8'd1, 1'b0}},
        '{'{CH_CR, 1'b0},    1'b1, 1'b0, NO_RES},
        '{'{CH_LF, 1'b0},    1'b1, 1'b1, '{8'h00, KIND_RECORD, 8'd1, 1'b0}},
        // empty record, by newline and by end of input
        '{'{CH_LF, 1'b0},    1'b1, 1'b0, NO_RES},
        '{'{8'hFF, 1'b1},    1'b1, 1'b0, NO_RES},
        // line holding only a carriage return
        '{'{CH_CR, 1'b0},    1'b1, 1'b0, NO_RES},
        '{'{CH_LF, 1'b0},    1'b1, 1'b1, '{8'h00, KIND_RECORD, 8'd0, 1'b0}},
        // quoted field with CR, doubled quote and comma inside
        '{'{CH_QUOTE, 1'b0}, 1'b0, 1'b0, NO_RES},
        '{'{8'h78, 1'b0},    1'b0, 1'b0, NO_RES},
        '{'{CH_CR, 1'b0},    1'b0, 1'b0, NO_RES},
        '{'{CH_QUOTE, 1'b0}, 1'b0, 1'b0, NO_RES},
        '{'{CH_QUOTE, 1'b0}, 1'b0, 1'b0, NO_RES},
        '{'{CH_COMMA, 1'b0}, 1'b0, 1'b0, NO_RES},
        '{'{CH_QUOTE, 1'b0}, 1'b0, 1'b0, NO_RES},
        '{'{CH_COMMA, 1'b0}, 1'b0, 1'b0, NO_RES},
        // newline inside open quotes
        '{'{CH_QUOTE, 1'b0}, 1'b0, 1'b0, NO_RES},
        '{'{CH_LF, 1'b0},    1'b1, 1'b1, '{8'h00, KIND_RECORD, 8'd1, 1'b1}},
        // pending quote closed by end of input
        '{'{CH_QUOTE, 1'b0}, 1'b0, 1'b0, NO_RES},
        '{'{CH_QUOTE, 1'b0}, 1'b0, 1'b0, NO_RES},
        '{'{8'h00, 1'b1},    1'b1, 1'b1, '{8'h00, KIND_RECORD, 8'd0, 1'b0}},
        // partial last line closed by end of input
        '{'{8'h6B, 1'b0},    1'b0, 1'b0, NO_RES},
        '{'{8'h55, 1'b1},    1'b1, 1'b1, '{8'h00, KIND_RECORD, 8'd0, 1'b0}}
    };

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    // Scanner state of the predictor
    t_quote_mode      scan_mode;
    logic             scan_line_on;
    logic [FLD_BITS-1:0] scan_field;

    t_out_item expected_results [$];
    int        errors      = 0;
    int        items_sent  = 0;
    int        sender_idle = 0;
    int        recv_stall  = 0;
    logic      hold_go     = 1'b0;
    logic      out_hold    = 1'b0;

    csv_record_field_splitter_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Advance the predicted scanner by one byte; return 1 when a result is due
    function automatic bit predict_split(input t_in_item it, output t_out_item res);
        res = '0;
        res.field_index = scan_field;
        if (it.end_of_input || it.in_byte == CH_LF) begin
            predict_split = scan_line_on;
            res.kind = KIND_RECORD;
            res.bad_record = (scan_mode == QM_QUOTED);
            scan_mode = QM_PLAIN;
            scan_line_on = 1'b0;
            scan_field = '0;
            return predict_split;
        end
        scan_line_on = 1'b1;
        if (scan_mode == QM_QUOTED) begin
            if (it.in_byte == CH_QUOTE) begin
                scan_mode = QM_PENDING;
                return 1'b0;
            end
            res.out_byte = it.in_byte;
            res.kind = KIND_BYTE;
            return 1'b1;
        end
        if (scan_mode == QM_PENDING) begin
            if (it.in_byte == CH_QUOTE) begin
                scan_mode = QM_QUOTED;
                res.out_byte = CH_QUOTE;
                res.kind = KIND_BYTE;
                return 1'b1;
            end
            scan_mode = QM_PLAIN;
        end
        // Unquoted byte
        case (it.in_byte)
            CH_QUOTE: begin
                scan_mode = QM_QUOTED;
                return 1'b0;
            end
            CH_COMMA: begin
                res.kind = KIND_FIELD;
                if (scan_field < FLD_MAX)
                    scan_field = scan_field + 1'b1;
                return 1'b1;
            end
            CH_CR: return 1'b0;
            default: begin
                res.out_byte = it.in_byte;
                res.kind = KIND_BYTE;
                return 1'b1;
            end
        endcase
    endfunction

    function automatic logic [7:0] plain_text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (b == CH_QUOTE || b == CH_COMMA || b == CH_CR || b == CH_LF)
            b = 8'($urandom_range(255));
        return b;
    endfunction

    function automatic logic [7:0] quoted_text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (b == CH_QUOTE || b == CH_LF)
            b = 8'($urandom_range(255));
        return b;
    endfunction

    // Offer one transaction, hold it until accepted, then record its expected result
    task automatic send_item(input t_in_item it, input bit use_fixed, input bit fix_has,
                             input t_out_item fix_res);
        t_out_item res;
        bit        has;
        while ($urandom_range(99) < sender_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        has = predict_split(it, res);
        if (use_fixed) begin
            has = fix_has;
            res = fix_res;
        end
        if (has)
            expected_results = {expected_results, res};
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        t_in_item it;
        it.in_byte = b;
        it.end_of_input = 1'b0;
        send_item(it, 1'b0, 1'b0, NO_RES);
    endtask

    task automatic send_end_of_input();
        t_in_item it;
        it.in_byte = 8'($urandom_range(255));
        it.end_of_input = 1'b1;
        send_item(it, 1'b0, 1'b0, NO_RES);
    endtask

    // Well-formed record: plain, quoted or empty fields, then LF, CRLF or end of input
    task automatic send_record();
        int nf;
        int kind_pick;
        int len;
        int end_pick;
        nf = $urandom_range(1, 6);
        for (int f = 0; f < nf; f++) begin
            if (f > 0)
                send_byte(CH_COMMA);
            kind_pick = $urandom_range(99);
            len = $urandom_range(0, 6);
            if (kind_pick < 55) begin
                for (int i = 0; i < len; i++)
                    send_byte(($urandom_range(19) == 0) ? CH_CR : plain_text_byte());
            end else if (kind_pick < 90) begin
                send_byte(CH_QUOTE);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(99) < 15) begin
                        send_byte(CH_QUOTE);
                        send_byte(CH_QUOTE);
                    end else begin
                        send_byte(quoted_text_byte());
                    end
                end
                send_byte(CH_QUOTE);
            end
        end
        end_pick = $urandom_range(99);
        if (end_pick < 70) begin
            send_byte(CH_LF);
        end else if (end_pick < 90) begin
            send_byte(CH_CR);
            send_byte(CH_LF);
        end else begin
            send_end_of_input();
        end
    endtask

    // Short burst of raw bytes weighted toward the special codes
    task automatic send_noise();
        int n;
        int pick;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(9);
            case (pick)
                0: send_end_of_input();
                1: send_byte(CH_QUOTE);
                2: send_byte(CH_COMMA);
                3: send_byte(CH_CR);
                4: send_byte(CH_LF);
                default: send_byte(8'($urandom_range(255)));
            endcase
        end
    endtask

    // Record that ends with a quote still open
    task automatic send_broken();
        int n;
        n = $urandom_range(0, 3);
        send_byte(CH_QUOTE);
        for (int i = 0; i < n; i++)
            send_byte(quoted_text_byte());
        if ($urandom_range(2) == 0)
            send_end_of_input();
        else
            send_byte(CH_LF);
    endtask

    // Compare one accepted result with the oldest expectation
    task automatic check_result(input t_out_item got);
        t_out_item exp_res;
        if (expected_results.size() == 0) begin
            $error("unexpected result: byte %02h kind %0d field %0d bad %0b",
                   got.out_byte, got.kind, got.field_index, got.bad_record);
            errors++;
            return;
        end
        exp_res = expected_results.pop_front();
        if (got.kind !== exp_res.kind) begin
            $error("kind: expected %0d, got %0d", exp_res.kind, got.kind);
            errors++;
        end
        if (got.out_byte !== exp_res.out_byte) begin
            $error("out_byte: expected %02h, got %02h", exp_res.out_byte, got.out_byte);
            errors++;
        end
        if (got.field_index !== exp_res.field_index) begin
            $error("field_index: expected %0d, got %0d", exp_res.field_index,
                   got.field_index);
            errors++;
        end
        if (got.bad_record !== exp_res.bad_record) begin
            $error("bad_record: expected %0b, got %0b", exp_res.bad_record,
                   got.bad_record);
            errors++;
        end
    endtask

    // Take results and drive ready with random stalls
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            check_result(o_out_data);
        i_out_ready <= !out_hold && ($urandom_range(99) >= recv_stall);
    end

    // Hold the result side off for a long stretch once requested
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        out_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        out_hold <= 1'b0;
    end

    // Stop a hung run
    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    initial begin
        int phase_start;
        int pick;
        bit hold_armed;
        hold_armed = 1'b0;
        scan_mode = QM_PLAIN;
        scan_line_on = 1'b0;
        scan_field = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table with no idling
        for (int r = 0; r < DIR_N; r++)
            send_item(DIR_ROWS[r].item, DIR_ROWS[r].fixed, DIR_ROWS[r].has_res,
                      DIR_ROWS[r].res);

        for (int ph = 0; ph < 4; ph++) begin
            sender_idle = SEND_IDLE[ph];
            recv_stall <= RECV_STALL[ph];
            phase_start = items_sent;
            // Drive the field counter past saturation
            if (ph == 3) begin
                send_byte(8'h41);
                for (int i = 0; i < FLD_MAX + 10; i++)
                    send_byte(CH_COMMA);
                send_byte(CH_LF);
                phase_start = items_sent;
            end
            while (items_sent < phase_start + PHASE_ITEMS) begin
                if (ph == 0 && !hold_armed && items_sent >= phase_start + 40) begin
                    hold_go <= 1'b1;
                    hold_armed = 1'b1;
                end
                pick = $urandom_range(99);
                if (pick < 75)
                    send_record();
                else if (pick < 88)
                    send_noise();
                else
                    send_broken();
            end
        end

        // Drain: drop valid, wait for every expected result, then let the pipe settle
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (expected_results.size() != 0)
            $error("%0d expected results never arrived", expected_results.size());
        if (errors == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
design/csvs_pkg.sv
design/csvs_step.sv
design/csv_record_field_splitter_core.sv
design/csvs_checker.sv
verif/tb_csv_record_field_splitter_core.sv
